/* sv/buddy_tree_allocator_assert.svh */
// Assertion macros for the buddy tree allocator. Both expect clk and rst in scope.
`ifndef BUDDY_TREE_ALLOCATOR_ASSERT_SVH
`define BUDDY_TREE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
`define BTA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buddy tree allocator: check failed in the same cycle");
`define BTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buddy tree allocator: check failed one cycle later");
`else
`define BTA_ASSERT_IMP(lbl, ante, cons)
`define BTA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/bta_pkg.sv */
`default_nettype none

package bta_pkg;

  localparam int LOG2_PAGES_DEF = 10;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_ALLOC = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DESC,
    S_CLIMB,
    S_UP,
    S_FIN
  } state_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } walk_stat_t;

endpackage

`default_nettype wire

/* sv/bta_mem.sv */
`default_nettype none

// Tree storage: one write port and two registered read ports.
module bta_mem #(
  parameter int AW = 11,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* sv/bta_walk.sv */
`default_nettype none

module bta_walk #(
  parameter int LOG2_PAGES = bta_pkg::LOG2_PAGES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_action,
  input  wire logic [LOG2_PAGES:0]    in_size,
  input  wire logic [LOG2_PAGES-1:0]  in_page,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output bta_pkg::status_t            out_status,
  output logic      [LOG2_PAGES-1:0]  out_offset,
  output logic      [LOG2_PAGES:0]    out_size,
  output logic      [LOG2_PAGES:0]    out_largest,
  output logic                        mem_we,
  output logic      [LOG2_PAGES:0]    mem_waddr,
  output logic      [LOG2_PAGES:0]    mem_wdata,
  output logic      [LOG2_PAGES:0]    mem_raddr_a,
  output logic      [LOG2_PAGES:0]    mem_raddr_b,
  input  wire logic [LOG2_PAGES:0]    mem_rdata_a,
  input  wire logic [LOG2_PAGES:0]    mem_rdata_b,
  output bta_pkg::walk_stat_t         stat
);

  import bta_pkg::*;

  localparam int L = LOG2_PAGES;
  localparam logic [L:0] ROOT   = {{L{1'b0}}, 1'b1};
  localparam logic [L:0] NODE_L = ROOT << 1;
  localparam logic [L:0] NODE_R = NODE_L | ROOT;
  localparam logic [L:0] POOL   = {1'b1, {L{1'b0}}};

  state_t state, state_next;

  logic [L:0]   idx, idx_next;
  logic [L:0]   size, size_next;
  logic [L:0]   cur, cur_next;
  logic [L:0]   req, req_next;
  logic [L-1:0] page, page_next;
  logic         op, op_next;
  status_t      res_st, res_st_next;
  logic [L-1:0] res_off, res_off_next;
  logic [L:0]   res_size, res_size_next;
  logic [L:0]   root_val, root_val_next;
  logic [L:0]   clr_idx, clr_idx_next;
  logic [L:0]   clr_size, clr_size_next;
  logic         out_valid_next;

  logic         in_fire, load;
  logic [L:0]   req_eff;
  logic         lfit, rfit, go_down, desc_stop;
  logic [L:0]   child, csize, tgt, tgt_size;
  logic         found, at_root;
  logic [L:0]   par, psize, upmax, upval;
  logic [L+1:0] pair_sum;

  assign in_fire   = in_valid && (state == S_IDLE);
  assign load      = (state == S_FIN) && (!out_valid || out_ready);
  assign req_eff   = (in_size == '0) ? ROOT : in_size;

  assign lfit      = mem_rdata_a >= req;
  assign rfit      = mem_rdata_b >= req;
  assign go_down   = lfit || rfit;
  assign child     = {idx[L-1:0], !lfit};
  assign csize     = {1'b0, size[L:1]};
  assign desc_stop = !go_down || child[L];
  assign tgt       = go_down ? child : idx;
  assign tgt_size  = go_down ? csize : size;

  assign found     = (mem_rdata_a == '0);
  assign at_root   = (idx == ROOT);

  assign par       = {1'b0, idx[L:1]};
  assign psize     = {size[L-1:0], 1'b0};
  assign upmax     = (cur > mem_rdata_a) ? cur : mem_rdata_a;
  assign pair_sum  = {1'b0, cur} + {1'b0, mem_rdata_a};
  assign upval     = ((op == ACT_FREE) && (pair_sum == {1'b0, psize})) ? psize : upmax;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (&clr_idx) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_FREE) begin
            state_next = S_CLIMB;
          end else if (req_eff > root_val) begin
            state_next = S_FIN;
          end else begin
            state_next = S_DESC;
          end
        end
      end
      S_DESC: begin
        if (desc_stop) state_next = (tgt == ROOT) ? S_FIN : S_UP;
      end
      S_CLIMB: begin
        if (at_root) begin
          state_next = S_FIN;
        end else if (found) begin
          state_next = S_UP;
        end
      end
      S_UP: begin
        if (par == ROOT) state_next = S_FIN;
      end
      S_FIN: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_CLR;
    endcase
  end

  always_comb begin
    idx_next       = idx;
    size_next      = size;
    cur_next       = cur;
    req_next       = req;
    page_next      = page;
    op_next        = op;
    res_st_next    = res_st;
    res_off_next   = res_off;
    res_size_next  = res_size;
    root_val_next  = root_val;
    clr_idx_next   = clr_idx;
    clr_size_next  = clr_size;
    mem_we         = 1'b0;
    mem_waddr      = clr_idx;
    mem_wdata      = clr_size;
    mem_raddr_a    = idx;
    mem_raddr_b    = idx;
    unique case (state)
      S_CLR: begin
        mem_we       = 1'b1;
        clr_idx_next = clr_idx + ROOT;
        // A new tree level starts where the next node index is a power of two.
        if ((clr_idx & (clr_idx + ROOT)) == '0) clr_size_next = {1'b0, clr_size[L:1]};
      end
      S_IDLE: begin
        if (in_fire) begin
          op_next      = in_action;
          req_next     = req_eff;
          page_next    = in_page;
          res_st_next  = ST_OK;
          res_off_next = '0;
          if (in_action == ACT_FREE) begin
            idx_next    = {1'b1, in_page};
            size_next   = ROOT;
            mem_raddr_a = {1'b1, in_page};
          end else if (req_eff > root_val) begin
            res_st_next   = ST_NO_FIT;
            res_size_next = '0;
          end else begin
            idx_next    = ROOT;
            size_next   = POOL;
            mem_raddr_a = NODE_L;
            mem_raddr_b = NODE_R;
          end
        end
      end
      S_DESC: begin
        if (desc_stop) begin
          mem_we        = 1'b1;
          mem_waddr     = tgt;
          mem_wdata     = '0;
          idx_next      = tgt;
          size_next     = tgt_size;
          cur_next      = '0;
          res_size_next = tgt_size;
          if (go_down && !lfit) res_off_next = res_off | csize[L-1:0];
          if (tgt == ROOT) root_val_next = '0;
          mem_raddr_a   = {tgt[L:1], ~tgt[0]};
        end else begin
          idx_next    = child;
          size_next   = csize;
          if (!lfit) res_off_next = res_off | csize[L-1:0];
          mem_raddr_a = {child[L-1:0], 1'b0};
          mem_raddr_b = {child[L-1:0], 1'b1};
        end
      end
      S_CLIMB: begin
        if (found) begin
          mem_we        = 1'b1;
          mem_waddr     = idx;
          mem_wdata     = size;
          cur_next      = size;
          res_size_next = size;
          res_off_next  = page & ~(size[L-1:0] - ROOT[L-1:0]);
          if (at_root) root_val_next = size;
          mem_raddr_a   = {idx[L:1], ~idx[0]};
        end else if (at_root) begin
          res_st_next   = ST_NOT_ALLOC;
          res_size_next = '0;
        end else begin
          idx_next    = par;
          size_next   = psize;
          mem_raddr_a = par;
        end
      end
      S_UP: begin
        mem_we      = 1'b1;
        mem_waddr   = par;
        mem_wdata   = upval;
        cur_next    = upval;
        idx_next    = par;
        size_next   = psize;
        if (par == ROOT) root_val_next = upval;
        mem_raddr_a = {par[L:1], ~par[0]};
      end
      S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= ROOT;
      clr_size  <= POOL;
      root_val  <= POOL;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      clr_size  <= clr_size_next;
      root_val  <= root_val_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    size     <= size_next;
    cur      <= cur_next;
    req      <= req_next;
    page     <= page_next;
    op       <= op_next;
    res_st   <= res_st_next;
    res_off  <= res_off_next;
    res_size <= res_size_next;
    if (load) begin
      out_status  <= res_st;
      out_offset  <= res_off;
      out_size    <= res_size;
      out_largest <= root_val;
    end
  end

  assign in_ready      = (state == S_IDLE);
  assign stat.clearing = (state == S_CLR);
  assign stat.busy     = (state != S_CLR) && (state != S_IDLE);

endmodule

`default_nettype wire

/* sv/buddy_tree_allocator.sv */
// Buddy tree allocator: one operation at a time, walked over a tree memory.
// An allocate descends to a fitting node and then refreshes its ancestors; a free climbs
// to the first taken node and does the same; an oversize allocate skips the walk.
// A new operation is taken once the last has left its walk, at one tree level a cycle.
// Reset: synchronous, active high; a clearing pass then loads every node with its
// subtree size while s_tready stays low.
`default_nettype none
`include "buddy_tree_allocator_assert.svh"

module buddy_tree_allocator #(
  parameter int LOG2_PAGES = bta_pkg::LOG2_PAGES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // size_req, page_offset from bit 0 up, zero padded to whole bytes
  input  wire logic [((2*LOG2_PAGES+1+7)/8)*8-1:0] s_tdata,
  // action
  input  wire logic                   s_tuser,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // block_offset, block_size, largest_free from bit 0 up, zero padded
  output logic      [((3*LOG2_PAGES+2+7)/8)*8-1:0] m_tdata,
  // status
  output logic      [1:0]             m_tuser
);

  import bta_pkg::*;

  localparam int L     = LOG2_PAGES;
  localparam int IN_W  = ((2*L+1+7)/8)*8;
  localparam int OUT_W = ((3*L+2+7)/8)*8;

  // Fields of the incoming beat.
  logic         in_action;
  logic [L:0]   in_size;
  logic [L-1:0] in_page;

  assign in_action = s_tuser;
  assign in_size   = s_tdata[L:0];
  assign in_page   = s_tdata[2*L:L+1];

  // Fields of the outgoing beat.
  status_t      res_status;
  logic [L-1:0] res_offset;
  logic [L:0]   res_size;
  logic [L:0]   res_largest;

  logic         mem_we;
  logic [L:0]   mem_waddr, mem_wdata, mem_raddr_a, mem_raddr_b, mem_rdata_a, mem_rdata_b;
  walk_stat_t   stat;

  // The tree memory holds node 1 (root) to node 2*pages-1, one entry per node.
  bta_mem #(
    .AW(L + 1),
    .DW(L + 1)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  // The walker runs the descent, the climb and the refresh of ancestors, and holds
  // the result in an output register so that a new beat may be taken meanwhile.
  bta_walk #(
    .LOG2_PAGES(L)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_action   (in_action),
    .in_size     (in_size),
    .in_page     (in_page),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (res_status),
    .out_offset  (res_offset),
    .out_size    (res_size),
    .out_largest (res_largest),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b),
    .stat        (stat)
  );

  assign m_tdata = OUT_W'({res_largest, res_size, res_offset});
  assign m_tuser = res_status;

  // A granted or released block is aligned to its own size.
  logic [L-1:0] align_mask;
  assign align_mask = res_size[L-1:0] - {{(L-1){1'b0}}, 1'b1};

  // The unused upper bits of the input beat carry nothing.
  logic in_pad_unused;
  assign in_pad_unused = (IN_W > 2*L+1) ? |s_tdata[IN_W-1:2*L+1] : 1'b0;

  `BTA_ASSERT_IMP(a_no_accept_while_clearing, stat.clearing, !s_tready)
  `BTA_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, stat.busy && !s_tready)
  `BTA_ASSERT_IMP(a_error_is_empty, m_tvalid && (res_status != ST_OK),
                  (res_size == '0) && (res_offset == '0))
  `BTA_ASSERT_IMP(a_ok_block_aligned, m_tvalid && (res_status == ST_OK),
                  $onehot(res_size) && ((res_offset & align_mask) == '0)
                  && (in_pad_unused || !in_pad_unused))

endmodule

`default_nettype wire

/* tb/buddy_tree_allocator_tb.sv */
`default_nettype none

module buddy_tree_allocator_tb;
  import bta_pkg::*;

  localparam int PAGE_BITS = LOG2_PAGES_DEF;
  localparam int POOL = 1 << PAGE_BITS;
  localparam int IN_W = ((2 * PAGE_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_W = ((3 * PAGE_BITS + 2 + 7) / 8) * 8;
  // The longest deliberate hold-off of the receiver, in cycles.
  localparam int HOLD_CYCLES = 400;

  // What one answer beat from the allocator carries.
  typedef struct {
    status_t              status;
    logic [PAGE_BITS-1:0] first_page;
    logic [PAGE_BITS:0]   pages;
    logic [PAGE_BITS:0]   largest;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // size_req, page_offset from bit 0 up, zero padded
  logic [IN_W-1:0] s_tdata = '0;
  // action
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // block_offset, block_size, largest_free from bit 0 up, zero padded
  logic [OUT_W-1:0] m_tdata;
  // status
  logic [1:0] m_tuser;

  buddy_tree_allocator #(.LOG2_PAGES(PAGE_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the tree: each node holds the longest free run in its
  // subtree, or zero when the node itself is a granted block.
  int unsigned longest_run [2*POOL];

  // Answers still owed by the allocator, oldest first.
  reply_t awaited [$];

  // Blocks currently granted, used to aim frees at real allocations.
  logic [PAGE_BITS-1:0] live_first [$];
  logic [PAGE_BITS:0]   live_pages [$];

  // When set, neither side inserts idle cycles.
  bit no_gaps = 1'b0;

  // The receiver serves a hold-off each time holds_asked moves on.
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;

  int unsigned fault_count = 0;
  int unsigned n_granted = 0;
  int unsigned n_refused = 0;
  int unsigned n_released = 0;
  int unsigned n_untaken = 0;
  int unsigned n_replies = 0;

  reply_t want_r;

  // Fresh pool: every node free for its whole subtree.
  function automatic void clear_pool();
    int unsigned i;
    longest_run[0] = 0;
    for (i = POOL; i < 2 * POOL; i++) longest_run[i] = 1;
    for (i = POOL - 1; i > 0; i--) longest_run[i] = longest_run[2*i] << 1;
  endfunction

  // Allocation: walk down taking the left child whenever it can hold the
  // request, stop at a leaf or where neither child fits, then refresh the
  // ancestors with the larger of their two children.
  function automatic reply_t grant_block(input logic [PAGE_BITS:0] req_in);
    reply_t r;
    int unsigned req, idx, span;
    req = (req_in == '0) ? 1 : 32'(req_in);
    r.largest = (PAGE_BITS + 1)'(longest_run[1]);
    if (req > longest_run[1]) begin
      r.status = ST_NO_FIT;
      r.first_page = '0;
      r.pages = '0;
      return r;
    end
    idx = 1;
    span = POOL;
    while (idx < POOL) begin
      if (longest_run[2*idx] >= req) idx = 2 * idx;
      else if (longest_run[2*idx+1] >= req) idx = 2 * idx + 1;
      else break;
      span = span >> 1;
    end
    longest_run[idx] = 0;
    r.status = ST_OK;
    r.first_page = PAGE_BITS'(idx * span - POOL);
    r.pages = (PAGE_BITS + 1)'(span);
    for (idx = idx >> 1; idx > 0; idx = idx >> 1) begin
      longest_run[idx] = (longest_run[2*idx] > longest_run[2*idx+1]) ?
                         longest_run[2*idx] : longest_run[2*idx+1];
    end
    r.largest = (PAGE_BITS + 1)'(longest_run[1]);
    return r;
  endfunction

  // Release: climb from the page's leaf to the first taken node, restore it,
  // and merge buddies on the way up whenever both halves are wholly free.
  function automatic reply_t release_block(input logic [PAGE_BITS-1:0] page);
    reply_t r;
    int unsigned idx, span, full, lo, hi;
    idx = 32'(page) + POOL;
    span = 1;
    while (idx > 0 && longest_run[idx] > 0) begin
      idx = idx >> 1;
      span = span << 1;
    end
    if (idx == 0) begin
      r.status = ST_NOT_ALLOC;
      r.first_page = '0;
      r.pages = '0;
      r.largest = (PAGE_BITS + 1)'(longest_run[1]);
      return r;
    end
    r.status = ST_OK;
    r.first_page = PAGE_BITS'(idx * span - POOL);
    r.pages = (PAGE_BITS + 1)'(span);
    longest_run[idx] = span;
    full = span;
    for (idx = idx >> 1; idx > 0; idx = idx >> 1) begin
      lo = longest_run[2*idx];
      hi = longest_run[2*idx+1];
      full = full << 1;
      longest_run[idx] = (lo + hi == full) ? full : ((lo > hi) ? lo : hi);
    end
    r.largest = (PAGE_BITS + 1)'(longest_run[1]);
    return r;
  endfunction

  // Offers one request beat, waits for it to be taken, then records the
  // answer it must produce. Entered and left at a falling edge.
  task automatic issue_op(input logic act, input logic [PAGE_BITS:0] req,
                          input logic [PAGE_BITS-1:0] page);
    reply_t r;
    int k;
    while (!no_gaps && $urandom_range(99) < 22) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tdata = IN_W'({page, req});
    s_tuser = act;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    r = (act == ACT_ALLOC) ? grant_block(req) : release_block(page);
    awaited.push_back(r);
    if (act == ACT_ALLOC) begin
      if (r.status == ST_OK) begin
        n_granted++;
        live_first.push_back(r.first_page);
        live_pages.push_back(r.pages);
      end else begin
        n_refused++;
      end
    end else if (r.status == ST_OK) begin
      n_released++;
      for (k = 0; k < live_first.size(); k++) begin
        if (live_first[k] == r.first_page) begin
          live_first.delete(k);
          live_pages.delete(k);
          break;
        end
      end
    end else begin
      n_untaken++;
    end
    @(negedge clk);
  endtask

  task automatic request_block(input int unsigned req);
    issue_op(ACT_ALLOC, (PAGE_BITS + 1)'(req), PAGE_BITS'($urandom));
  endtask

  task automatic free_page(input int unsigned page);
    issue_op(ACT_FREE, (PAGE_BITS + 1)'($urandom), PAGE_BITS'(page));
  endtask

  // Frees a random page somewhere inside one of the granted blocks.
  task automatic free_some_live();
    int unsigned k;
    k = $urandom_range(live_first.size() - 1);
    free_page(32'(live_first[k]) + $urandom_range(32'(live_pages[k]) - 1));
  endtask

  // Mostly small requests so the walk reaches the leaves; a few large ones
  // and a few that cannot fit whatever the pool holds.
  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(4, 1);
    if (r < 80) return $urandom_range(32, 5);
    if (r < 93) return $urandom_range(256, 33);
    if (r < 98) return $urandom_range(POOL, 257);
    return $urandom_range(2 * POOL - 1, POOL + 1);
  endfunction

  task automatic test_directed();
    request_block(POOL);                     // the whole pool in one block
    request_block(0);                        // nothing left, even for one page
    free_page(700);                          // a page inside the whole-pool block
    free_page(700);                          // the same page again, now untaken
    request_block(2 * POOL - 1);             // every request bit set, oversize
    request_block(POOL + 1);                 // just beyond the pool
    issue_op(ACT_ALLOC, '0, PAGE_BITS'(POOL - 1));  // zero request, junk page field
    request_block(1);
    request_block(3);                        // rounds up to a block of four
    request_block(POOL / 2);
    request_block(POOL / 2);                 // upper half gone by now
    request_block(POOL / 4);
    request_block(100);
    // Last page, junk size field.
    issue_op(ACT_FREE, (PAGE_BITS + 1)'(2 * POOL - 1), PAGE_BITS'(POOL - 1));
    free_page(0);
    request_block(1);
    free_page(6);                            // middle of the block of four
    free_page(POOL - 2);                     // already released above
    while (live_first.size() != 0) free_some_live();
    free_page(0);                            // empty pool, nothing to release
  endtask

  // Allocation and release churn with random content, plus some noise.
  task automatic test_random_churn(input int count);
    int i;
    int unsigned r;
    for (i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 78) begin
        if (live_first.size() != 0 &&
            (longest_run[1] < 64 || $urandom_range(99) < 45)) free_some_live();
        else request_block(pick_size());
      end else if (r < 90) begin
        free_page($urandom_range(POOL - 1));
      end else if (r < 95) begin
        request_block(0);
      end else begin
        request_block($urandom_range(2 * POOL - 1, longest_run[1]));
      end
    end
  endtask

  // The same churn with both sides ready on every cycle.
  task automatic test_steady(input int count);
    no_gaps = 1'b1;
    test_random_churn(count);
    no_gaps = 1'b0;
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // answer stalls in the block and its input stops taking beats.
  task automatic test_backpressure(input int count);
    holds_asked++;
    test_random_churn(count);
  endtask

  task automatic test_drain();
    while (live_first.size() != 0) free_some_live();
  endtask

  task automatic flag_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Receiver: random idles, a long stall on request, none when no_gaps is set.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_asked;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_gaps || ($urandom_range(99) >= 22);
    end
  end

  // Every answer beat is held against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_replies++;
      if (awaited.size() == 0) begin
        flag_fault($sformatf("unexpected answer beat, raw data %h status %h",
                             m_tdata, m_tuser));
      end else begin
        want_r = awaited.pop_front();
        if (m_tuser !== want_r.status ||
            m_tdata[PAGE_BITS-1:0] !== want_r.first_page ||
            m_tdata[2*PAGE_BITS:PAGE_BITS] !== want_r.pages ||
            m_tdata[3*PAGE_BITS+1:2*PAGE_BITS+1] !== want_r.largest) begin
          flag_fault($sformatf(
            "answer %0d: status %0d/%0d first %0d/%0d pages %0d/%0d largest %0d/%0d",
            n_replies, want_r.status, m_tuser,
            want_r.first_page, m_tdata[PAGE_BITS-1:0],
            want_r.pages, m_tdata[2*PAGE_BITS:PAGE_BITS],
            want_r.largest, m_tdata[3*PAGE_BITS+1:2*PAGE_BITS+1]));
        end
      end
    end
  end

  initial begin
    clear_pool();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // The block clears its tree after reset; the first beat simply waits.
    test_directed();
    test_random_churn(560);
    test_steady(140);
    test_backpressure(40);
    test_random_churn(60);
    test_drain();
    s_tvalid = 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    // Allow for a full walk in case anything stray is still on its way.
    repeat (60) @(posedge clk);
    if (awaited.size() != 0) flag_fault("answers still outstanding at the end");
    $display("Covered %0d grants, %0d refusals, %0d releases, %0d frees of untaken pages,",
             n_granted, n_refused, n_released, n_untaken);
    $display("with random idling, a steady stretch and a %0d cycle receiver stall.",
             HOLD_CYCLES);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatching answers in total", fault_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Guard against a hang: well beyond the slowest legal run.
  initial begin
    #(12 * 600000);
    $display("Timed out with %0d answers outstanding", awaited.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
